// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the frame checker RTL.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/mbe_pkg.sv =====
// Types, constants and functions of the Modbus Euler frame checker.
// No dependencies; imported by every module of the block.
package mbe_pkg;

	// Result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_ADDR  = 3'd1;
	localparam logic [2:0] ST_BAD_FUNC  = 3'd2;
	localparam logic [2:0] ST_BAD_COUNT = 3'd3;
	localparam logic [2:0] ST_BAD_CRC   = 3'd4;

	// Byte positions within the 11-byte response
	localparam logic [3:0] POS_ADDR     = 4'd0;
	localparam logic [3:0] POS_FUNC     = 4'd1;
	localparam logic [3:0] POS_COUNT    = 4'd2;
	localparam logic [3:0] POS_ROLL_HI  = 4'd3;
	localparam logic [3:0] POS_ROLL_LO  = 4'd4;
	localparam logic [3:0] POS_PITCH_HI = 4'd5;
	localparam logic [3:0] POS_PITCH_LO = 4'd6;
	localparam logic [3:0] POS_YAW_HI   = 4'd7;
	localparam logic [3:0] POS_YAW_LO   = 4'd8;
	localparam logic [3:0] POS_CRC_LO   = 4'd9;
	localparam logic [3:0] POS_CRC_HI   = 4'd10;
	localparam logic [3:0] POS_DONE     = 4'd11;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDR = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FUNC_CODE  = 8'd1;
	localparam logic [7:0] SLAVE_ADDR_RST = 8'h50;
	localparam logic [7:0] FUNC_CODE_RST  = 8'h03;

	// Protocol constants
	localparam logic [7:0]  EXPECTED_COUNT = 8'h06;
	localparam logic [15:0] CRC_INIT       = 16'hFFFF;
	localparam logic [15:0] CRC_POLY       = 16'hA001;
	localparam logic signed [8:0] ANGLE_SCALE = 9'sd180;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} in_item_t;

	typedef struct packed {
		logic               has_result;
		logic [2:0]         status;
		logic signed [15:0] roll;
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
	} core_out_t;

	// One byte of reflected CRC-16/MODBUS, eight shift steps
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
			input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// raw * 180 with arithmetic shift right by 8, kept to 16 bits
	function automatic logic signed [15:0] scale_angle(input logic signed [15:0] raw);
		logic signed [24:0] prod;
		prod = raw * ANGLE_SCALE;
		return prod[23:8];
	endfunction

endpackage

// ===== hdl/mbe_in_reg.sv =====
// Input register stage of the frame checker: holds one received byte.
// Depends on mbe_pkg for the item type.
module mbe_in_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  mbe_pkg::in_item_t in_item,
	output logic             valid_s1,
	output mbe_pkg::in_item_t item_s1,
	input  logic             take_s1
);
	import mbe_pkg::*;

	// Accept when empty or when the held byte moves on this cycle
	assign in_ready = !valid_s1 || take_s1;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Load payload on each transfer
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== hdl/mbe_frame_core.sv =====
// Frame state, CRC update, header checks and angle scaling of the checker.
// Depends on mbe_pkg for constants, types, crc16_byte and scale_angle.
module mbe_frame_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        slave_address,
	input  logic [7:0]        function_code,
	input  logic              valid_s1,
	input  mbe_pkg::in_item_t item_s1,
	input  logic              advance,
	output mbe_pkg::core_out_t core_out
);
	import mbe_pkg::*;

	logic [3:0]         pos_q;
	logic [15:0]        crc_q;
	logic [2:0]         err_q;
	logic [7:0]         hi_q;
	logic signed [15:0] angle_q [3];

	logic [3:0]         pos_eff;
	logic [15:0]        crc_eff;
	logic [2:0]         err_eff;
	logic [2:0]         code;
	logic [2:0]         err_new;
	logic [15:0]        crc_new;
	logic               active;
	logic               hi_wr;
	logic               ang_wr;
	logic [1:0]         ang_idx;
	logic signed [15:0] scaled;
	logic [7:0]         b;

	assign b = item_s1.rx_byte;

	// A frame start restarts position, CRC and error before this byte
	assign pos_eff = item_s1.frame_start ? POS_ADDR : pos_q;
	assign crc_eff = item_s1.frame_start ? CRC_INIT : crc_q;
	assign err_eff = item_s1.frame_start ? ST_OK : err_q;
	assign active  = (pos_eff < POS_DONE);
	assign crc_new = crc16_byte(crc_eff, b);
	assign scaled  = scale_angle($signed({hi_q, b}));

	// Decode the check and angle write for this position
	always_comb begin
		code    = ST_OK;
		hi_wr   = 1'b0;
		ang_wr  = 1'b0;
		ang_idx = 2'd0;
		case (pos_eff)
			POS_ADDR:     if (b != slave_address) code = ST_BAD_ADDR;
			POS_FUNC:     if (b != function_code) code = ST_BAD_FUNC;
			POS_COUNT:    if (b != EXPECTED_COUNT) code = ST_BAD_COUNT;
			POS_ROLL_HI,
			POS_PITCH_HI,
			POS_YAW_HI:   hi_wr = 1'b1;
			POS_ROLL_LO:  begin
				ang_wr  = 1'b1;
				ang_idx = 2'd0;
			end
			POS_PITCH_LO: begin
				ang_wr  = 1'b1;
				ang_idx = 2'd1;
			end
			POS_YAW_LO:   begin
				ang_wr  = 1'b1;
				ang_idx = 2'd2;
			end
			POS_CRC_LO:   if (b != crc_eff[7:0]) code = ST_BAD_CRC;
			POS_CRC_HI:   if (b != crc_eff[15:8]) code = ST_BAD_CRC;
			default:      code = ST_OK;
		endcase
	end

	// Keep the first failure of the frame
	assign err_new = (err_eff == ST_OK) ? code : err_eff;

	// Result on the last byte; angles are zeroed for a failed frame
	always_comb begin
		core_out.has_result = valid_s1 && (pos_eff == POS_CRC_HI);
		core_out.status     = err_new;
		if (err_new == ST_OK) begin
			core_out.roll  = angle_q[0];
			core_out.pitch = angle_q[1];
			core_out.yaw   = angle_q[2];
		end else begin
			core_out.roll  = '0;
			core_out.pitch = '0;
			core_out.yaw   = '0;
		end
	end

	// Advance frame control state; bytes past the end only honour a restart
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_ADDR;
			crc_q <= CRC_INIT;
			err_q <= ST_OK;
		end else if (advance) begin
			if (active) begin
				pos_q <= pos_eff + 4'd1;
				err_q <= err_new;
				if (pos_eff <= POS_YAW_LO) begin
					crc_q <= crc_new;
				end else begin
					crc_q <= crc_eff;
				end
			end else begin
				pos_q <= pos_eff;
				crc_q <= crc_eff;
				err_q <= err_eff;
			end
		end
	end

	// Hold high byte, then store the scaled angle once the pair is complete
	always_ff @(posedge clk) begin
		if (advance && hi_wr) begin
			hi_q <= b;
		end
		if (advance && ang_wr) begin
			angle_q[ang_idx] <= scaled;
		end
	end

endmodule

// ===== hdl/modbus_euler_frame_checker_top.sv =====
// Top level of the Modbus RTU Euler-angle response checker.
// Depends on mbe_pkg, mbe_in_reg, mbe_frame_core and assert_macros.svh.
//
// Takes an 11-byte Modbus RTU read response one byte per transfer, at a
// sustained rate of one byte per clock unless a finished result waits on
// out_ready. Each byte passes an input register, then combinational logic
// (one CRC-16/MODBUS byte step and one 16x9 multiplier for the angle
// scaling) into the result register, which is loaded from the last byte.
// Raise frame_start with byte 0 of every frame; bytes after byte 10 are
// dropped until the next frame start. Status is 0 ok, 1 bad address, 2 bad
// function, 3 bad byte count, 4 CRC mismatch; the first failure wins and
// the angles read 0 when status is not ok. Angles are in 1/128 degree.
// Write the configuration registers only while no frame is in flight.
`include "assert_macros.svh"
module modbus_euler_frame_checker_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mbe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [7:0]                      cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      rx_byte,
	input  logic                            frame_start,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [2:0]                      status,
	output logic signed [15:0]              roll_angle,
	output logic signed [15:0]              pitch_angle,
	output logic signed [15:0]              yaw_angle
);
	import mbe_pkg::*;

	logic [7:0]  slave_addr_q;
	logic [7:0]  func_code_q;
	in_item_t    in_item;
	in_item_t    item_s1;
	logic        valid_s1;
	logic        advance;
	logic        load_out;
	core_out_t   core_out;
	logic        out_valid_q;
	logic [2:0]  status_q;
	logic signed [15:0] roll_q;
	logic signed [15:0] pitch_q;
	logic signed [15:0] yaw_q;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= SLAVE_ADDR_RST;
			func_code_q  <= FUNC_CODE_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_SLAVE_ADDR) begin
				slave_addr_q <= cfg_data;
			end
			if (cfg_index == CFG_FUNC_CODE) begin
				func_code_q <= cfg_data;
			end
		end
	end

	assign in_item.rx_byte     = rx_byte;
	assign in_item.frame_start = frame_start;

	mbe_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.take_s1  (advance)
	);

	// Stall only a byte that yields a result while the result register is full and not read
	assign advance  = valid_s1 && (!core_out.has_result || !out_valid_q || out_ready);
	assign load_out = advance && core_out.has_result;

	mbe_frame_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.slave_address (slave_addr_q),
		.function_code (func_code_q),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1),
		.advance       (advance),
		.core_out      (core_out)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q <= core_out.status;
			roll_q   <= core_out.roll;
			pitch_q  <= core_out.pitch;
			yaw_q    <= core_out.yaw;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign roll_angle  = roll_q;
	assign pitch_angle = pitch_q;
	assign yaw_angle   = yaw_q;

	// Checks
	`ASSERT_IMPL(a_fail_zero, clk, arst_n, out_valid_q && (status_q != ST_OK), (roll_q == 16'sd0) && (pitch_q == 16'sd0) && (yaw_q == 16'sd0), "failed frame with nonzero angles")
	`ASSERT_IMPL(a_status_range, clk, arst_n, out_valid_q, status_q <= ST_BAD_CRC, "status code out of range")
	`ASSERT_NEXT(a_load_shows, clk, arst_n, load_out, out_valid_q, "loaded result not presented")
	`ASSERT_IMPL(a_stall_held, clk, arst_n, !in_ready, valid_s1 && core_out.has_result && out_valid_q, "input stalled without a blocked result")

endmodule
